// ----- rtl/char_range_expander_top_macros.svh -----
// ----------------------------------------------------------------------------
// char_range_expander_top_macros
// assertion macros for the checker of the range expander
// ----------------------------------------------------------------------------
`ifndef CHAR_RANGE_EXPANDER_TOP_MACROS_SVH
`define CHAR_RANGE_EXPANDER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CRE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("char_range_expander: same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("char_range_expander: next-cycle check failed");

`endif

// ----- rtl/cre_pkg.sv -----
// ----------------------------------------------------------------------------
// cre_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package cre_pkg;

    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;

    // what the oldest window position turns into
    typedef enum logic [2:0] {
        CLS_COPY,
        CLS_DASH,
        CLS_RANGE,
        CLS_MISMATCH,
        CLS_SKIP
    } pos_class_t;

    // source of an emitted byte
    typedef enum logic [1:0] {
        SEL_CUR,
        SEL_PREV,
        SEL_DASH,
        SEL_RUN
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      advance;
        logic      run_init;
        logic      run_step;
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_last;
    } cre_cmd_t;

    typedef struct packed {
        pos_class_t cls;
        logic [1:0] count;
        logic       last;
        logic       run_more;
        logic       out_free;
    } cre_status_t;

endpackage

// ----- rtl/cre_datapath.sv -----
// ----------------------------------------------------------------------------
// cre_datapath
// source window, range run cursor and output register
// ----------------------------------------------------------------------------
module cre_datapath
    import cre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cre_cmd_t          cmd,
    output cre_status_t       status,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last
);

    logic [CHAR_W-1:0] win_reg [3];
    logic [CHAR_W-1:0] win_next [3];
    logic [1:0]        cnt_reg, cnt_next;
    logic              last_reg, last_next;
    logic [CHAR_W-1:0] prev_reg, prev_next;
    logic              start_reg, start_next;
    logic [CHAR_W-1:0] run_next_reg, run_next_next;
    logic [CHAR_W-1:0] run_stop_reg, run_stop_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic              has1, has2, range_ok, is_dash;
    pos_class_t        cls;
    logic [CHAR_W-1:0] emit_byte;

    // classification of the oldest position
    assign has1    = (cnt_reg >= 2'd2);
    assign has2    = (cnt_reg == 2'd3);
    assign is_dash = (win_reg[0] == CHAR_DASH);
    assign range_ok = ((prev_reg >= CHAR_LOWER_A) && (win_reg[1] <= CHAR_LOWER_Z)) ||
                      ((prev_reg >= CHAR_UPPER_A) && (win_reg[1] <= CHAR_UPPER_Z)) ||
                      ((prev_reg >= CHAR_DIGIT_0) && (win_reg[1] <= CHAR_DIGIT_9));

    always_comb
    begin
        if (is_dash) begin
            if (start_reg || !has1)
                cls = CLS_DASH;
            else if (range_ok)
                cls = CLS_RANGE;
            else
                cls = CLS_MISMATCH;
        end
        else if (has1 && has2 && (win_reg[1] == CHAR_DASH))
            cls = CLS_SKIP;
        else
            cls = CLS_COPY;
    end

    always_comb
    begin
        case (cmd.emit_sel)
            SEL_CUR:  emit_byte = win_reg[0];
            SEL_PREV: emit_byte = prev_reg;
            SEL_DASH: emit_byte = CHAR_DASH;
            SEL_RUN:  emit_byte = run_next_reg;
            default:  emit_byte = win_reg[0];
        endcase
    end

    always_comb
    begin
        win_next      = win_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        prev_next     = prev_reg;
        start_next    = start_reg;
        run_next_next = run_next_reg;
        run_stop_next = run_stop_reg;

        if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                if (cnt_reg == 2'(i))
                    win_next[i] = in_char;
            end
            cnt_next  = cnt_reg + 2'd1;
            last_next = in_last;
        end

        if (cmd.advance) begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            cnt_next    = cnt_reg - 2'd1;
            if (last_reg && (cnt_reg == 2'd1)) begin
                // string done, window back to its start condition
                prev_next  = '0;
                start_next = 1'b1;
                last_next  = 1'b0;
            end
            else begin
                prev_next  = win_reg[0];
                start_next = 1'b0;
            end
        end

        if (cmd.run_init) begin
            run_next_next = prev_reg;
            run_stop_next = win_reg[1];
        end
        else if (cmd.run_step)
            run_next_next = run_next_reg + 8'd1;
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_char_next  = emit_byte;
            out_last_next  = cmd.emit_last;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            prev_reg      <= '0;
            start_reg     <= 1'b1;
            run_next_reg  <= '0;
            run_stop_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            prev_reg      <= prev_next;
            start_reg     <= start_next;
            run_next_reg  <= run_next_next;
            run_stop_reg  <= run_stop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg      <= win_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign status.cls      = cls;
    assign status.count    = cnt_reg;
    assign status.last     = last_reg;
    assign status.run_more = (run_next_reg < run_stop_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- rtl/cre_controller.sv -----
// ----------------------------------------------------------------------------
// cre_controller
// sequences window fill, position decisions and range runs
// ----------------------------------------------------------------------------
module cre_controller
    import cre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cre_status_t status,
    output cre_cmd_t    cmd,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RUN,
        ST_DASH
    } state_t;

    state_t state_reg, state_next;
    state_t after_adv;
    logic   final_pos;

    // final position of a closed string
    assign final_pos = status.last && (status.count == 2'd1);
    assign after_adv = (status.last && !final_pos) ? ST_EVAL : ST_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    if (in_last || (status.count == 2'd2))
                        state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                case (status.cls)
                    CLS_COPY, CLS_DASH:
                    begin
                        if (status.out_free) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_sel  = (status.cls == CLS_DASH) ? SEL_DASH : SEL_CUR;
                            cmd.emit_last = final_pos;
                            cmd.advance   = 1'b1;
                            state_next    = after_adv;
                        end
                    end
                    CLS_SKIP:
                    begin
                        cmd.advance = 1'b1;
                        state_next  = after_adv;
                    end
                    CLS_MISMATCH:
                    begin
                        if (status.out_free) begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = SEL_PREV;
                            state_next   = ST_DASH;
                        end
                    end
                    CLS_RANGE:
                    begin
                        cmd.run_init = 1'b1;
                        state_next   = ST_RUN;
                    end
                    default:
                    begin
                        cmd.advance = 1'b1;
                        state_next  = after_adv;
                    end
                endcase
            end

            ST_RUN:
            begin
                if (status.run_more) begin
                    if (status.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = SEL_RUN;
                        cmd.run_step = 1'b1;
                    end
                end
                else begin
                    cmd.advance = 1'b1;
                    state_next  = after_adv;
                end
            end

            ST_DASH:
            begin
                if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_DASH;
                    cmd.advance  = 1'b1;
                    state_next   = after_adv;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/char_range_expander_top.sv -----
// ----------------------------------------------------------------------------
// char_range_expander_top
// expands shorthand ranges such as a-z in a byte stream
// ----------------------------------------------------------------------------
// order: a position is decided in the cycle after the item that completes
//   its window (two items later, or the tlast item); a copied byte enters the
//   output register with that decision, a range's first byte only from ST_RUN
// flow: items are taken only in ST_IDLE, not while positions are decided;
//   copy, dash or skipped range start is settled in ST_EVAL, a mismatch emits
//   prev_reg then a dash, a range its run (up to 25); output stalls hold emits
// reset: rst_n low empties the window count, clears the run cursor and the output valid
module char_range_expander_top
    import cre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] in_char
    input  logic              s_axis_tlast,   // in_last
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [CHAR_W-1:0] m_axis_tdata,   // [7:0] out_char
    output logic              m_axis_tlast    // out_last
);

    cre_cmd_t    cmd;
    cre_status_t status;

    // controller: takes items only while idle, then walks the window
    // positions one at a time, draining any range run byte by byte
    cre_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .cmd      (cmd),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready)
    );

    // datapath: three-byte window with previous byte, range cursor and the
    // output register that decouples the output stream from the controller
    cre_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_char   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ----- rtl/cre_checker.sv -----
// ----------------------------------------------------------------------------
// cre_checker
// port-level checks for the range expander, bound to the top level
// ----------------------------------------------------------------------------
`include "char_range_expander_top_macros.svh"

module cre_checker
    import cre_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [CHAR_W-1:0] s_axis_tdata,
    input logic              s_axis_tlast,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [CHAR_W-1:0] m_axis_tdata,
    input logic              m_axis_tlast
);

    // a stalled output item holds
    `CRE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tlast}))

    // the end of a string always triggers decisions, so input closes
    `CRE_ASSERT_NEXT(a_last_closes_input, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

    // new output only comes from decision cycles, never from idle
    `CRE_ASSERT_SAME(a_out_from_work, $rose(m_axis_tvalid), $past(!s_axis_tready))

    // an offered output item carries known bits
    `CRE_ASSERT_SAME(a_tdata_known, m_axis_tvalid, !$isunknown({m_axis_tdata, m_axis_tlast}))

    // an offered input item carries known bits
    `CRE_ASSERT_SAME(a_in_known, s_axis_tvalid, !$isunknown({s_axis_tdata, s_axis_tlast}))

endmodule

bind char_range_expander_top cre_checker u_cre_checker (.*);
